[hw/rtl/lqi_pkg.sv]
// Shared types and constants for the LQI control law unit.
// Used by lqi_mac, lqi_control_law_unit and the testbench; depends on nothing.
`default_nettype none

package lqi_pkg;

    localparam int LQI_MAX_STATES      = 16;
    localparam int LQI_MAX_DRIVES      = 8;
    localparam int LQI_MAX_INTEGRATORS = 8;
    localparam int LQI_FRAC_BITS       = 16;

    localparam int LQI_DATA_W = 32;
    localparam int LQI_ACC_W  = 64;

    // Input word kinds carried on tuser
    typedef enum logic [1:0] {
        OP_LOAD_SG = 2'd0,
        OP_LOAD_IG = 2'd1,
        OP_STATE   = 2'd2,
        OP_ERROR   = 2'd3
    } t_opcode;

    // Configuration register indexes
    localparam logic [1:0] CFG_STATE_COUNT      = 2'd0;
    localparam logic [1:0] CFG_DRIVE_COUNT      = 2'd1;
    localparam logic [1:0] CFG_INTEGRATOR_COUNT = 2'd2;
    localparam logic [1:0] CFG_ANTI_WINDUP      = 2'd3;

    // Anti-windup modes (mode 3 behaves as AW_ALWAYS)
    localparam logic [1:0] AW_ALWAYS = 2'd0;
    localparam logic [1:0] AW_CLEAR  = 2'd1;
    localparam logic [1:0] AW_HOLD   = 2'd2;

    // Sequencer to MAC control
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

`default_nettype wire

[hw/rtl/lqi_mac.sv]
// Shared multiply-accumulate unit: registered 32x32 signed product, then a
// saturating 64-bit accumulate. Depends on lqi_pkg.
`default_nettype none

module lqi_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire lqi_pkg::t_mac_ctl                      i_ctl,
    input  wire logic signed [lqi_pkg::LQI_DATA_W-1:0]  i_a,
    input  wire logic signed [lqi_pkg::LQI_DATA_W-1:0]  i_b,
    output logic signed      [lqi_pkg::LQI_ACC_W-1:0]   o_acc,
    output logic                                        o_clip,
    output logic                                        o_busy
);
    import lqi_pkg::*;

    logic signed [LQI_ACC_W-1:0] r_prod;
    logic                        r_prod_v;
    logic signed [LQI_ACC_W-1:0] r_acc;
    logic                        r_clip;
    logic signed [LQI_ACC_W-1:0] w_sum;
    logic                        w_ovf;

    assign w_sum = r_acc + r_prod;
    // overflow when both operands share a sign that the sum does not
    assign w_ovf = (r_acc[LQI_ACC_W-1] == r_prod[LQI_ACC_W-1]) &&
                   (w_sum[LQI_ACC_W-1] != r_prod[LQI_ACC_W-1]);

    always_ff @(posedge i_clk) begin
        r_prod <= LQI_ACC_W'(i_a) * LQI_ACC_W'(i_b);
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_acc    <= '0;
            r_clip   <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.valid;
            if (i_ctl.clear) begin
                r_acc  <= '0;
                r_clip <= 1'b0;
            end else if (r_prod_v) begin
                if (w_ovf) begin
                    r_acc  <= r_prod[LQI_ACC_W-1] ? {1'b1, {(LQI_ACC_W-1){1'b0}}}
                                                  : {1'b0, {(LQI_ACC_W-1){1'b1}}};
                    r_clip <= 1'b1;
                end else begin
                    r_acc <= w_sum;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_clip = r_clip;
    assign o_busy = r_prod_v;

endmodule

`default_nettype wire

[hw/rtl/lqi_control_law_unit.sv]
// LQI control law unit: gain, sample and integrator stores, the step
// sequencer and the output register. Depends on lqi_pkg and lqi_mac.
`default_nettype none

// Load words (opcodes 0..2) are stored as they are accepted. An error
// word goes through S_INT for the integrator read-modify-write. When it
// carries tlast, a step follows: for each drive output the sequencer walks
// state_count plus integrator_count multiply-accumulates through the single
// shared MAC, one issue per cycle, then waits for the read, multiply and
// accumulate stages to drain, rounds and saturates the sum into the output
// register and waits for m_axis_tready. s_axis_tready is low for the
// whole step.
module lqi_control_law_unit #(
    parameter int MAX_STATES      = lqi_pkg::LQI_MAX_STATES,
    parameter int MAX_DRIVES      = lqi_pkg::LQI_MAX_DRIVES,
    parameter int MAX_INTEGRATORS = lqi_pkg::LQI_MAX_INTEGRATORS,
    parameter int FRAC_BITS       = lqi_pkg::LQI_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // gain_row[2:0], gain_col[6:3], element_index[10:7], data_value[42:11]
    input  wire logic [47:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // last_error
    input  wire logic        s_axis_tlast,
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // drive_value[31:0]
    output logic [31:0]      m_axis_tdata,
    // drive_index[2:0], saturated[3]
    output logic [3:0]       m_axis_tuser,
    // drive_last
    output logic             m_axis_tlast
);
    import lqi_pkg::*;

    localparam int SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int DW  = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;
    localparam int IW  = (MAX_INTEGRATORS > 1) ? $clog2(MAX_INTEGRATORS) : 1;
    localparam int CW  = (SW > IW) ? SW : IW;
    localparam int NSW = $clog2(MAX_STATES + 1);
    localparam int NDW = $clog2(MAX_DRIVES + 1);
    localparam int NIW = $clog2(MAX_INTEGRATORS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_INT, S_STATE, S_INTEG, S_DRAIN, S_OUT
    } t_state;

    // configuration registers
    logic [4:0] r_state_count;
    logic [3:0] r_drive_count;
    logic [3:0] r_integ_count;
    logic [1:0] r_aw_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= 5'd1;
            r_drive_count <= 4'd1;
            r_integ_count <= 4'd1;
            r_aw_mode     <= AW_ALWAYS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATE_COUNT:      r_state_count <= i_cfg_data;
                CFG_DRIVE_COUNT:      r_drive_count <= i_cfg_data[3:0];
                CFG_INTEGRATOR_COUNT: r_integ_count <= i_cfg_data[3:0];
                CFG_ANTI_WINDUP:      r_aw_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // effective counts: zero acts as one, too large acts as the maximum
    logic [NSW-1:0] w_ns;
    logic [NDW-1:0] w_nd;
    logic [NIW-1:0] w_ni;

    always_comb begin
        if (r_state_count == '0)                   w_ns = NSW'(1);
        else if (32'(r_state_count) > MAX_STATES)  w_ns = NSW'(MAX_STATES);
        else                                       w_ns = NSW'(r_state_count);
        if (r_drive_count == '0)                   w_nd = NDW'(1);
        else if (32'(r_drive_count) > MAX_DRIVES)  w_nd = NDW'(MAX_DRIVES);
        else                                       w_nd = NDW'(r_drive_count);
        if (r_integ_count == '0)                   w_ni = NIW'(1);
        else if (32'(r_integ_count) > MAX_INTEGRATORS) w_ni = NIW'(MAX_INTEGRATORS);
        else                                       w_ni = NIW'(r_integ_count);
    end

    // input word fields
    t_opcode            w_op;
    logic [2:0]         w_in_row;
    logic [3:0]         w_in_col;
    logic [3:0]         w_in_idx;
    logic signed [31:0] w_in_data;
    logic               w_accept;

    assign w_op      = t_opcode'(s_axis_tuser);
    assign w_in_row  = s_axis_tdata[2:0];
    assign w_in_col  = s_axis_tdata[6:3];
    assign w_in_idx  = s_axis_tdata[10:7];
    assign w_in_data = s_axis_tdata[42:11];
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    t_state             r_fsm;
    logic [DW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [IW-1:0]      r_err_idx;
    logic               r_err_upd;
    logic signed [31:0] r_err_data;
    logic               r_err_last;
    logic               r_rd_v;
    logic               r_rd_sel;
    logic [31:0]        r_out_data;
    logic [DW-1:0]      r_out_idx;
    logic               r_out_last;
    logic               r_out_sat;

    // stores
    logic signed [31:0] r_sg_mem [0:(1 << (DW + SW)) - 1];
    logic signed [31:0] r_ig_mem [0:(1 << (DW + IW)) - 1];
    logic signed [31:0] r_ss_mem [0:(1 << SW) - 1];
    logic signed [31:0] r_xi_mem [0:(1 << IW) - 1];
    logic [(1 << IW) - 1:0] r_xi_vld;
    logic signed [31:0] r_sg_q;
    logic signed [31:0] r_ig_q;
    logic signed [31:0] r_ss_q;
    logic signed [31:0] r_xi_q;
    logic               r_xi_ok;
    logic signed [31:0] w_xi;
    logic [IW-1:0]      w_xi_raddr;
    logic signed [31:0] w_xi_new;
    logic               w_xi_we;

    assign w_xi_raddr = (r_fsm == S_IDLE) ? IW'(w_in_idx) : r_col[IW-1:0];
    assign w_xi       = r_xi_ok ? r_xi_q : '0;
    assign w_xi_we    = (r_fsm == S_INT) && r_err_upd;

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_LOAD_SG) &&
            (32'(w_in_row) < MAX_DRIVES) && (32'(w_in_col) < MAX_STATES)) begin
            r_sg_mem[{DW'(w_in_row), SW'(w_in_col)}] <= w_in_data;
        end
        if (w_accept && (w_op == OP_LOAD_IG) &&
            (32'(w_in_row) < MAX_DRIVES) && (32'(w_in_col) < MAX_INTEGRATORS)) begin
            r_ig_mem[{DW'(w_in_row), IW'(w_in_col)}] <= w_in_data;
        end
        if (w_accept && (w_op == OP_STATE) && (32'(w_in_idx) < MAX_STATES)) begin
            r_ss_mem[SW'(w_in_idx)] <= w_in_data;
        end
        if (w_xi_we) begin
            r_xi_mem[r_err_idx] <= w_xi_new;
        end
        r_sg_q <= r_sg_mem[{r_row, r_col[SW-1:0]}];
        r_ig_q <= r_ig_mem[{r_row, r_col[IW-1:0]}];
        r_ss_q <= r_ss_mem[r_col[SW-1:0]];
        r_xi_q <= r_xi_mem[w_xi_raddr];
    end

    // integrator valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xi_vld <= '0;
            r_xi_ok  <= 1'b0;
        end else begin
            r_xi_ok <= r_xi_vld[w_xi_raddr];
            if (w_xi_we) begin
                r_xi_vld[r_err_idx] <= 1'b1;
            end
        end
    end

    // integrator update under the anti-windup mode
    logic signed [32:0] w_xi_sum;
    logic signed [31:0] w_xi_sat;
    logic               w_err_neg;

    assign w_xi_sum  = {w_xi[31], w_xi} + {r_err_data[31], r_err_data};
    assign w_err_neg = r_err_data[31];

    always_comb begin
        if (w_xi_sum[32] != w_xi_sum[31]) begin
            w_xi_sat = w_xi_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_xi_sat = w_xi_sum[31:0];
        end
        case (r_aw_mode)
            AW_CLEAR: w_xi_new = w_err_neg ? w_xi_sat : '0;
            AW_HOLD:  w_xi_new = w_err_neg ? w_xi_sat : w_xi;
            default:  w_xi_new = w_xi_sat;
        endcase
    end

    // shared MAC
    t_mac_ctl                    w_mac_ctl;
    logic signed [31:0]          w_mac_a;
    logic signed [31:0]          w_mac_b;
    logic signed [LQI_ACC_W-1:0] w_acc;
    logic                        w_acc_clip;
    logic                        w_mac_busy;

    assign w_mac_a         = r_rd_sel ? r_ig_q : r_sg_q;
    assign w_mac_b         = r_rd_sel ? w_xi   : r_ss_q;
    assign w_mac_ctl.valid = r_rd_v;
    assign w_mac_ctl.clear = ((r_fsm == S_INT) && r_err_last) ||
                             ((r_fsm == S_OUT) && m_axis_tready && !r_out_last);

    lqi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc),
        .o_clip  (w_acc_clip),
        .o_busy  (w_mac_busy)
    );

    // round toward minus infinity, negate, saturate
    logic signed [LQI_ACC_W-1:0] w_shift;
    logic signed [LQI_ACC_W-1:0] w_neg;
    logic [31:0]                 w_res;
    logic                        w_res_clip;

    assign w_shift = w_acc >>> FRAC_BITS;
    assign w_neg   = -w_shift;

    always_comb begin
        if (w_neg[LQI_ACC_W-1:31] == '0 || w_neg[LQI_ACC_W-1:31] == '1) begin
            w_res      = w_neg[31:0];
            w_res_clip = 1'b0;
        end else begin
            w_res      = w_neg[LQI_ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
            w_res_clip = 1'b1;
        end
    end

    logic w_col_last_s;
    logic w_col_last_i;

    assign w_col_last_s = (32'(r_col) == 32'(w_ns) - 32'd1);
    assign w_col_last_i = (32'(r_col) == 32'(w_ni) - 32'd1);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= S_IDLE;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v   <= (r_fsm == S_STATE) || (r_fsm == S_INTEG);
            r_rd_sel <= (r_fsm == S_INTEG);
            unique case (r_fsm)
                S_IDLE: begin
                    if (w_accept && (w_op == OP_ERROR)) begin
                        r_err_idx  <= IW'(w_in_idx);
                        r_err_upd  <= (32'(w_in_idx) < 32'(w_ni));
                        r_err_data <= w_in_data;
                        r_err_last <= s_axis_tlast;
                        r_fsm      <= S_INT;
                    end
                end
                S_INT: begin
                    r_row <= '0;
                    r_col <= '0;
                    r_fsm <= r_err_last ? S_STATE : S_IDLE;
                end
                S_STATE: begin
                    if (w_col_last_s) begin
                        r_col <= '0;
                        r_fsm <= S_INTEG;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_INTEG: begin
                    if (w_col_last_i) begin
                        r_fsm <= S_DRAIN;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_DRAIN: begin
                    // wait for the last product to land in the accumulator
                    if (!r_rd_v && !w_mac_busy) begin
                        r_out_data <= w_res;
                        r_out_idx  <= r_row;
                        r_out_last <= (32'(r_row) == 32'(w_nd) - 32'd1);
                        r_out_sat  <= w_acc_clip || w_res_clip;
                        r_fsm      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_out_last) begin
                            r_fsm <= S_IDLE;
                        end else begin
                            r_row <= r_row + DW'(1);
                            r_col <= '0;
                            r_fsm <= S_STATE;
                        end
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_fsm == S_IDLE);
    assign m_axis_tvalid = (r_fsm == S_OUT);
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = {r_out_sat, 3'(r_out_idx)};
    assign m_axis_tlast  = r_out_last;

    // one word at a time: never take input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    // an accepted error word always holds off input for the integrator update step
    a_err_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ERROR) |=> !s_axis_tready)
        else $error("error word did not hold off input");

    // the last drive output of a step returns the block to idle
    a_step_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not ready after the last drive output");

    // the walk never runs past the drive count
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_STATE) |-> (32'(r_row) < 32'(w_nd)))
        else $error("drive row beyond drive count");

    // results only leave once the MAC pipeline has drained
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!r_rd_v && !w_mac_busy))
        else $error("result shown while MAC still busy");

endmodule

`default_nettype wire

[test/tb_lqi_control_law_unit.sv]
// Self-checking testbench for lqi_control_law_unit: gain and sample loading,
// integrator anti-windup, count limits and random control steps under stalls.
// Depends on lqi_pkg and the RTL of the unit; drive words are predicted here.
module tb_lqi_control_law_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lqi_pkg::*;

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint Q_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN   = -Q_MAX - 1;
    localparam int     SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
        logic        sat;
    } t_drive;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_STATE_COUNT;
    logic [4:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_LOAD_SG;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predicted copy of the unit
    logic signed [31:0] sg_tab [LQI_MAX_DRIVES][LQI_MAX_STATES];
    logic signed [31:0] ig_tab [LQI_MAX_DRIVES][LQI_MAX_INTEGRATORS];
    logic signed [31:0] x_vec  [LQI_MAX_STATES];
    logic signed [31:0] xi_vec [LQI_MAX_INTEGRATORS] = '{default: '0};
    logic [4:0]         cfg_states = 5'd1;
    logic [3:0]         cfg_drives = 4'd1;
    logic [3:0]         cfg_integ  = 4'd1;
    logic [1:0]         cfg_aw     = AW_ALWAYS;

    t_drive expected_drives [$];
    int     fail_count   = 0;
    int     src_idle_pct = 14;
    int     dst_idle_pct = 68;

    lqi_control_law_unit u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    function automatic int unsigned eff_count(int unsigned v, int unsigned lim);
        return (v == 0) ? 1 : ((v > lim) ? lim : v);
    endfunction

    function automatic longint sat32(longint v);
        return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        if (b > 0 && a > ACC_MAX - b)
            return ACC_MAX;
        if (b < 0 && a < ACC_MIN - b)
            return ACC_MIN;
        return a + b;
    endfunction

    function automatic logic [31:0] rand_value(bit wide);
        int unsigned pick;
        pick = wide ? $urandom_range(0, 9) : 9;
        case (pick)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return $urandom();
            default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
        endcase
    endfunction

    task automatic predict_word(t_opcode op, logic [2:0] row, logic [3:0] col,
                                logic [3:0] idx, logic signed [31:0] data, logic last);
        int unsigned ns, nd, ni;
        int          i, j;
        longint      acc, term, sum, r;
        bit          clip;
        t_drive      d;
        ns = eff_count(cfg_states, LQI_MAX_STATES);
        nd = eff_count(cfg_drives, LQI_MAX_DRIVES);
        ni = eff_count(cfg_integ, LQI_MAX_INTEGRATORS);
        case (op)
            OP_LOAD_SG: sg_tab[row][col] = data;
            OP_LOAD_IG: begin
                if (col < LQI_MAX_INTEGRATORS)
                    ig_tab[row][col[2:0]] = data;
            end
            OP_STATE: x_vec[idx] = data;
            default: begin
                if (idx < ni) begin
                    sum = longint'(xi_vec[idx[2:0]]) + longint'(data);
                    case (cfg_aw)
                        AW_CLEAR: xi_vec[idx[2:0]] = (data < 0) ? 32'(sat32(sum)) : '0;
                        AW_HOLD: begin
                            if (data < 0)
                                xi_vec[idx[2:0]] = 32'(sat32(sum));
                        end
                        default: xi_vec[idx[2:0]] = 32'(sat32(sum));
                    endcase
                end
                if (last) begin
                    for (i = 0; i < nd; i++) begin
                        acc  = 0;
                        clip = 1'b0;
                        for (j = 0; j < ns + ni; j++) begin
                            term = (j < ns) ? longint'(sg_tab[i][j]) * longint'(x_vec[j])
                                 : longint'(ig_tab[i][j - ns]) * longint'(xi_vec[j - ns]);
                            sum = sat_sum(acc, term);
                            if (sum != acc + term)
                                clip = 1'b1;
                            acc = sum;
                        end
                        // floor shift, negate, clip to 32 bits
                        term = -(acc >>> LQI_FRAC_BITS);
                        r = sat32(term);
                        if (r != term)
                            clip = 1'b1;
                        d.value = r[31:0];
                        d.index = i[2:0];
                        d.last  = (i == nd - 1);
                        d.sat   = clip;
                        expected_drives.push_back(d);
                    end
                end
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(t_opcode op, logic [2:0] row, logic [3:0] col,
                             logic [3:0] idx, logic [31:0] data, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, data, idx, col, row};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(op, row, col, idx, data, last);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_STATE_COUNT:      cfg_states = value;
            CFG_DRIVE_COUNT:      cfg_drives = value[3:0];
            CFG_INTEGRATOR_COUNT: cfg_integ  = value[3:0];
            default:              cfg_aw     = value[1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(int unsigned ns, int unsigned nd, int unsigned ni, logic [1:0] aw);
        write_reg(CFG_STATE_COUNT, 5'(ns));
        write_reg(CFG_DRIVE_COUNT, 5'(nd));
        write_reg(CFG_INTEGRATOR_COUNT, 5'(ni));
        write_reg(CFG_ANTI_WINDUP, {3'b0, aw});
    endtask

    // drop valid, wait for every drive word, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_drives.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_preload();
        int r, c;
        for (r = 0; r < LQI_MAX_DRIVES; r++) begin
            for (c = 0; c < LQI_MAX_STATES; c++)
                send_word(OP_LOAD_SG, r[2:0], c[3:0], 4'($urandom_range(0, 15)),
                          rand_value(1'b0), 1'($urandom_range(0, 1)));
            for (c = 0; c < LQI_MAX_INTEGRATORS; c++)
                send_word(OP_LOAD_IG, r[2:0], c[3:0], 4'($urandom_range(0, 15)),
                          rand_value(1'b0), 1'($urandom_range(0, 1)));
        end
        for (c = 0; c < LQI_MAX_STATES; c++)
            send_word(OP_STATE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                      c[3:0], rand_value(1'b0), 1'b0);
        settle();
    endtask

    // full-scale products overflow the accumulator; integrators hit both rails
    task automatic test_extremes();
        configure(LQI_MAX_STATES, LQI_MAX_DRIVES, LQI_MAX_INTEGRATORS, AW_ALWAYS);
        send_word(OP_LOAD_SG, 3'd7, 4'd15, 4'd0, 32'h8000_0000, 1'b0);
        send_word(OP_LOAD_SG, 3'd7, 4'd14, 4'd0, 32'h8000_0000, 1'b0);
        send_word(OP_STATE, 3'd0, 4'd0, 4'd15, 32'h8000_0000, 1'b0);
        send_word(OP_STATE, 3'd7, 4'd15, 4'd14, 32'h8000_0000, 1'b0);
        send_word(OP_LOAD_IG, 3'd7, 4'd7, 4'd0, 32'h7FFF_FFFF, 1'b0);
        send_word(OP_ERROR, 3'd5, 4'd9, 4'd7, 32'h7FFF_FFFF, 1'b0);
        send_word(OP_ERROR, 3'd2, 4'd6, 4'd7, 32'h7FFF_FFFF, 1'b0);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd0, 32'h8000_0000, 1'b0);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd0, 32'h8000_0000, 1'b1);
        settle();
    endtask

    // out-of-range writes change nothing, and tlast on non-error words starts no step
    task automatic test_ignored_words();
        send_word(OP_LOAD_IG, 3'd2, 4'd9, 4'd0, 32'h7FFF_FFFF, 1'b1);
        send_word(OP_STATE, 3'd0, 4'd0, 4'd3, rand_value(1'b0), 1'b1);
        send_word(OP_LOAD_SG, 3'd1, 4'd2, 4'd0, rand_value(1'b0), 1'b1);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd12, 32'h7FFF_FFFF, 1'b1);
        settle();
        configure(LQI_MAX_STATES, LQI_MAX_DRIVES, 3, AW_ALWAYS);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd5, 32'h0001_0000, 1'b1);
        settle();
    endtask

    // zero counts act as one, counts above the maximum act as the maximum
    task automatic test_count_limits();
        configure(0, 0, 0, AW_ALWAYS);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd0, 32'hFFFF_0000, 1'b1);
        settle();
        configure(31, 15, 15, AW_ALWAYS);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd7, 32'h0000_8000, 1'b1);
        settle();
    endtask

    task automatic test_anti_windup();
        configure(4, 2, 2, AW_CLEAR);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd0, 32'hFFF0_0000, 1'b0);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd1, 32'hFFFF_8000, 1'b1);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd0, 32'h0000_0000, 1'b1);
        settle();
        configure(5, 4, 2, AW_HOLD);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd1, 32'h0010_0000, 1'b0);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd1, 32'hFFFE_0000, 1'b1);
        settle();
        // mode 3 behaves as always-integrate
        configure(6, 3, 4, 2'd3);
        send_word(OP_ERROR, 3'd0, 4'd0, 4'd2, 32'h0003_0000, 1'b1);
        settle();
    endtask

    task automatic test_random_steps();
        int          ph, sent, n, k;
        int unsigned ns, nd, ni, aw;
        for (ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0:       begin src_idle_pct = 14; dst_idle_pct = 68; end
                1:       begin src_idle_pct = 68; dst_idle_pct = 14; end
                default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
            endcase
            ns = $urandom_range(0, 31);
            nd = $urandom_range(0, 15);
            ni = $urandom_range(0, 15);
            aw = $urandom_range(0, 3);
            configure(ns, nd, ni, aw[1:0]);
            sent = 0;
            while (sent < 17) begin
                if ($urandom_range(0, 9) < 8) begin
                    // well-formed step: fresh states, then errors ending on tlast
                    n = $urandom_range(0, 3);
                    for (k = 0; k < n; k++)
                        send_word(OP_STATE, 3'($urandom_range(0, 7)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  rand_value(1'b1), 1'($urandom_range(0, 1)));
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        send_word(OP_ERROR, 3'($urandom_range(0, 7)),
                                  4'($urandom_range(0, 15)),
                                  4'($urandom_range(0, eff_count(ni, LQI_MAX_INTEGRATORS) - 1)),
                                  rand_value(1'b1), k == n - 1);
                    sent += 2 * n;
                end else begin
                    send_word(t_opcode'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              rand_value(1'b1), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            settle();
        end
    endtask

    always @(posedge i_clk) begin : check_drive
        t_drive seen, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.value = m_axis_tdata;
            seen.index = m_axis_tuser[2:0];
            seen.sat   = m_axis_tuser[3];
            seen.last  = m_axis_tlast;
            if (expected_drives.size() == 0) begin
                if (fail_count < 10)
                    $display("drive word with nothing pending: value %h index %0d last %b sat %b",
                             seen.value, seen.index, seen.last, seen.sat);
                fail_count++;
            end else begin
                want = expected_drives.pop_front();
                if (seen !== want) begin
                    if (fail_count < 10)
                        $display({"drive mismatch: exp value %h index %0d last %b sat %b,",
                                  " got value %h index %0d last %b sat %b"},
                                 want.value, want.index, want.last, want.sat,
                                 seen.value, seen.index, seen.last, seen.sat);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_preload();
        test_extremes();
        test_ignored_words();
        test_count_limits();
        test_anti_windup();
        test_random_steps();
        settle();
        if (fail_count == 0 && expected_drives.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lqi_pkg.sv
hw/rtl/lqi_mac.sv
hw/rtl/lqi_control_law_unit.sv
test/tb_lqi_control_law_unit.sv
